[rtl/gwd_pkg.sv]
package gwd_pkg;

  // Fixed field widths of the block.
  localparam int DATA_BITS   = 32;
  localparam int POLY_BITS   = 32;
  localparam int REG_BITS    = POLY_BITS + 1;
  localparam int RESULT_BITS = 63;
  localparam int CNT_BITS    = 6;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int SEL_BITS    = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLYNOMIAL    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_OUTPUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORD_WIDTH    = 2'd2;

  // Reset values of the configuration.
  localparam logic [POLY_BITS-1:0] POLY_RESET  = 32'd135169;
  localparam logic [CNT_BITS-1:0]  WIDTH_RESET = 6'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } gwd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic last;
  } gwd_sts_t;

  // A width of zero behaves as one, and widths above the data word clamp to it.
  function automatic logic [CNT_BITS-1:0] eff_width(input logic [CNT_BITS-1:0] w);
    logic [CNT_BITS-1:0] r;
    r = w;
    if (w == '0) begin
      r = CNT_BITS'(1);
    end else if (w > CNT_BITS'(DATA_BITS)) begin
      r = CNT_BITS'(DATA_BITS);
    end
    return r;
  endfunction

endpackage

[rtl/gwd_ifs.sv]
// Input channel: one scrambled word and the number of bits to descramble.
interface gwd_in_if import gwd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] data_word;
  logic [CNT_BITS-1:0]  bit_count;

  modport source (output valid, output data_word, output bit_count, input ready);
  modport sink   (input valid, input data_word, input bit_count, output ready);
endinterface

// Result channel: the shifted word with the descrambled bits at the bottom.
interface gwd_out_if import gwd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

[rtl/gwd_ctrl.sv]
module gwd_ctrl import gwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gwd_sts_t sts,
  output gwd_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // The result register is free when empty or when it is being taken now.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Command decode and next state.
  always_comb begin
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.push  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.zero) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag follows pushes and taken requests.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/gwd_dp.sv]
module gwd_dp import gwd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [DATA_BITS-1:0]     data_word,
  input  logic [CNT_BITS-1:0]      bit_count,
  input  gwd_cmd_t                 cmd,
  output gwd_sts_t                 sts,
  output logic [RESULT_BITS-1:0]   result_word
);

  logic [POLY_BITS-1:0]   poly_r;
  logic                   invert_r;
  logic [CNT_BITS-1:0]    width_r;
  logic [REG_BITS-1:0]    sreg_r, sreg_nxt;
  logic [RESULT_BITS-1:0] word_r, word_nxt;
  logic [RESULT_BITS-1:0] result_r;
  logic [CNT_BITS-1:0]    count_r, idx_r;

  logic [CNT_BITS-1:0]    width;
  logic [CNT_BITS-1:0]    count_sat;
  logic [SEL_BITS-1:0]    sel;
  logic [DATA_BITS-1:0]   word_low;
  logic [DATA_BITS-1:0]   low_mask;
  logic                   in_bit;
  logic [REG_BITS-1:0]    sreg_x;
  logic                   out_bit;

  assign width     = eff_width(width_r);
  assign count_sat = (bit_count > width) ? width : bit_count;

  // One descrambling step: take the top bit, feed the polynomial, enter the output bit.
  always_comb begin
    sel      = SEL_BITS'(width - CNT_BITS'(1));
    word_low = word_r[DATA_BITS-1:0];
    in_bit   = word_low[sel];
    low_mask = {DATA_BITS{1'b1}} >> (CNT_BITS'(DATA_BITS) - width);
    sreg_x   = sreg_r ^ (in_bit ? {1'b0, poly_r} : '0);
    out_bit  = sreg_x[0] ^ invert_r;
    word_nxt = {word_r[RESULT_BITS-2:0], out_bit};
    // At the step that completes a full word, the word is cut back to its width.
    if (idx_r == CNT_BITS'(sel)) begin
      word_nxt = word_nxt & {{(RESULT_BITS-DATA_BITS){1'b0}}, low_mask};
    end
    // Arithmetic right shift repeats the top bit.
    sreg_nxt = {sreg_x[REG_BITS-1], sreg_x[REG_BITS-1:1]};
  end

  assign sts.zero    = (count_r == '0);
  assign sts.last    = ((idx_r + CNT_BITS'(1)) == count_r);
  assign result_word = result_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= POLY_RESET;
      invert_r <= 1'b0;
      width_r  <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLYNOMIAL:    poly_r   <= cfg_data[POLY_BITS-1:0];
        CFG_INVERT_OUTPUT: invert_r <= cfg_data[0];
        CFG_WORD_WIDTH:    width_r  <= cfg_data[CNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The descrambler register keeps its state from item to item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sreg_r <= '1;
    end else if (cmd.step) begin
      sreg_r <= sreg_nxt;
    end
  end

  // Working word, step counters and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r  <= {{(RESULT_BITS-DATA_BITS){1'b0}}, data_word};
      count_r <= count_sat;
      idx_r   <= '0;
    end else if (cmd.step) begin
      word_r <= word_nxt;
      idx_r  <= idx_r + CNT_BITS'(1);
    end
    if (cmd.push) begin
      result_r <= word_r;
    end
  end

endmodule

[rtl/galois_word_descrambler_top.sv]
// Galois-form word descrambler. Each request carries a word and a bit count;
// that many bits, taken from position word_width-1 downwards, pass one per
// clock through a 33-bit Galois shift register, and one result is returned per
// request. A request with count n (saturated to word_width) is loaded, its n
// bits are stepped in the run state (none if n is zero), its result is loaded
// in the push state once the result register is free, and the next request is
// taken in idle. The result sits in its own register, so a new request may run
// while an earlier result waits to be taken. The user must write configuration
// through the cfg port while the block is idle; the block does not enforce it.
module galois_word_descrambler_top import gwd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  gwd_in_if.sink                   in_ch,
  gwd_out_if.source                out_ch
);

  gwd_cmd_t cmd;
  gwd_sts_t sts;

  // Sequencer for load, bit steps and result hand-off.
  gwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Shift register, working word and configuration.
  gwd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_word   (in_ch.data_word),
    .bit_count   (in_ch.bit_count),
    .cmd         (cmd),
    .sts         (sts),
    .result_word (out_ch.result_word)
  );

endmodule
